### rtl/bsb_pkg.sv
package bsb_pkg;

  localparam int MAX_SLOTS   = 16;
  localparam int MAX_READERS = 8;

  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int READER_W = $clog2(MAX_READERS);
  localparam int VALUE_W  = 31;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int NSLOT_W  = 5;
  localparam int NRDR_W   = 4;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READERS_IN_USE = 1'd1;

  localparam logic [NSLOT_W-1:0] SLOTS_RESET   = NSLOT_W'(16);
  localparam logic [NRDR_W-1:0]  READERS_RESET = NRDR_W'(8);

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_WRITTEN  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic exec;     // run the command, update table, load result register
  } bsb_cmd_t;

endpackage

### rtl/bsb_ctrl.sv
module bsb_ctrl
  import bsb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output bsb_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   can_load;

  assign in_stall    = (state != S_IDLE);
  assign can_load    = !out_valid || !out_stall;
  assign cmd.capture = in_valid && (state == S_IDLE);
  assign cmd.exec    = (state == S_EXEC) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // a held result blocks execution, so nothing to retire here
          if (can_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/bsb_datapath.sv
module bsb_datapath
  import bsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  bsb_cmd_t             cmd,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [FUNC_W-1:0]    func,
  input  logic [VALUE_W-1:0]   value,
  input  logic [READER_W-1:0]  reader,
  input  logic [SLOT_W-1:0]    slot_index,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot_written,
  output logic                 all_read
);

  // config
  logic [NSLOT_W-1:0] slots_in_use;
  logic [NRDR_W-1:0]  readers_in_use;

  // captured word
  logic [FUNC_W-1:0]   func_q;
  logic                value_nz_q;
  logic [READER_W-1:0] reader_q;
  logic [SLOT_W-1:0]   slot_q;

  // table: occupancy flags and per-slot read marks
  logic [MAX_SLOTS-1:0]   occ;
  logic [MAX_READERS-1:0] marks [MAX_SLOTS];

  logic [MAX_SLOTS-1:0]   scan_en;
  logic [MAX_SLOTS-1:0]   free_vec;
  logic [MAX_SLOTS-1:0]   unread_vec;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic [MAX_READERS-1:0] need;
  logic [MAX_READERS-1:0] rd_bit;
  logic [MAX_READERS-1:0] new_marks;
  logic                   already;
  logic                   frees;

  logic [STATUS_W-1:0] status_next;
  logic [SLOT_W-1:0]   written_next;
  logic                all_read_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use   <= SLOTS_RESET;
      readers_in_use <= READERS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOTS_IN_USE:   slots_in_use   <= cfg_data[NSLOT_W-1:0];
        CFG_READERS_IN_USE: readers_in_use <= cfg_data[NRDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= func;
      value_nz_q <= (value != '0);
      reader_q   <= reader;
      slot_q     <= slot_index;
    end
  end

  // slot window and active-reader mask; counts above the table saturate
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      scan_en[i] = (32'(slots_in_use) > i);
    end
    for (int j = 0; j < MAX_READERS; j++) begin
      need[j] = (32'(readers_in_use) > j);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_vec[i]   = scan_en[i] && !occ[i];
      unread_vec[i] = scan_en[i] && occ[i] && !marks[i][reader_q];
    end
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rd_bit    = MAX_READERS'(1) << reader_q;
    already   = (marks[slot_q] & rd_bit) != '0;
    new_marks = marks[slot_q] | rd_bit;
    frees     = (new_marks & need) == need;
  end

  always_comb begin
    status_next   = ST_WRITTEN;
    written_next  = '0;
    all_read_next = 1'b0;
    unique case (func_q)
      FUNC_WRITE: begin
        if (free_found) begin
          written_next = free_idx;
        end else begin
          status_next = ST_NO_SPACE;
        end
      end
      FUNC_READ: begin
        if (!occ[slot_q]) begin
          status_next = ST_EMPTY;
        end else if (already) begin
          status_next = ST_ALREADY;
        end else begin
          status_next = ST_READ_OK;
        end
      end
      FUNC_CHECK: all_read_next = (unread_vec == '0);
      default: ;
    endcase
  end

  // marks of an empty slot are never looked at: a write clears them first
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (cmd.exec) begin
      if (func_q == FUNC_WRITE && free_found) begin
        occ[free_idx] <= value_nz_q;
      end else if (func_q == FUNC_READ && occ[slot_q] && !already && frees) begin
        occ[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (func_q == FUNC_WRITE && free_found) begin
        marks[free_idx] <= '0;
      end else if (func_q == FUNC_READ && occ[slot_q] && !already) begin
        marks[slot_q] <= frees ? '0 : new_marks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= status_next;
      slot_written <= written_next;
      all_read     <= all_read_next;
    end
  end

endmodule

### rtl/broadcast_slot_buffer_unit.sv
// Broadcast slot buffer: one writer, up to eight readers, sixteen slots.
// func selects write (store value in the lowest empty slot among the first
// slots_in_use), read (reader marks slot_index; the slot frees once every
// reader below readers_in_use has marked it) or check (all_read = 1 when the
// reader has no occupied unmarked slot in the window). Each command word
// yields exactly one result word. A word is captured in the idle state; in
// the execute state the combinational slot scan (free-slot priority encoder
// or unread-slot OR) runs and the result register loads; the next word can be
// taken while the result still waits, and a stalled result holds execution
// of the following word until the result register frees. Writing a zero
// value reports written but leaves the slot empty. Config writes go straight
// to the registers; issue them only while no word is in flight.
module broadcast_slot_buffer_unit
  import bsb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [FUNC_W-1:0]    func,
  input  logic [VALUE_W-1:0]   value,
  input  logic [READER_W-1:0]  reader,
  input  logic [SLOT_W-1:0]    slot_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot_written,
  output logic                 all_read,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  bsb_cmd_t cmd;

  // sequencing: capture / execute / result handshake
  bsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // slot table, config registers, result register
  bsb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .value        (value),
    .reader       (reader),
    .slot_index   (slot_index),
    .status       (status),
    .slot_written (slot_written),
    .all_read     (all_read)
  );

  // an accepted word always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word still executing");

  // execution always produces a result and frees the input side
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid && !in_stall)
    else $error("executed word produced no result");

  // slot number is only reported on a successful write
  a_written_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_WRITTEN |-> slot_written == '0)
    else $error("slot_written nonzero on non-write result");

endmodule

### sim/broadcast_slot_buffer_unit_tb.sv
`timescale 1ns / 1ps

module broadcast_slot_buffer_unit_tb;
  import bsb_pkg::*;

  // func code with no operation behind it; the block answers with all-zero fields
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

  localparam int N_PHASES    = 9;
  localparam int PHASE_WORDS = 110;

  // register settings per random phase, extremes and out-of-range values included
  localparam logic [CFG_W-1:0] PHASE_SLOTS   [N_PHASES] = '{16, 1, 31, 0, 5, 9, 16, 3, 12};
  localparam logic [CFG_W-1:0] PHASE_READERS [N_PHASES] = '{8, 1, 31, 3, 0, 4, 2, 8, 6};

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [VALUE_W-1:0]  value;
    logic [READER_W-1:0] reader;
    logic [SLOT_W-1:0]   slot;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_written;
    logic                all_read;
  } result_t;

  // slot contents plus per-reader marks
  typedef struct packed {
    logic [MAX_SLOTS-1:0][VALUE_W-1:0]     val;
    logic [MAX_SLOTS-1:0][MAX_READERS-1:0] marks;
  } table_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func = FUNC_WRITE;
  logic [VALUE_W-1:0]   value = '0;
  logic [READER_W-1:0]  reader = '0;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot_written;
  logic                 all_read;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SLOTS_IN_USE;
  logic [CFG_W-1:0]     cfg_data = '0;

  broadcast_slot_buffer_unit dut (.*);

  cmd_t    cmd_backlog[$];      // words waiting for the driver
  result_t pending_results[$];  // predicted results, oldest first
  cmd_t    bus_cmd = '0;        // word currently on the input port
  result_t predicted;
  result_t observed;

  table_t  live_table = '0;     // table as the block holds it, updated on acceptance
  table_t  plan_table;          // look-ahead copy used to steer stimulus
  logic [NSLOT_W-1:0] slots_reg   = SLOTS_RESET;
  logic [NRDR_W-1:0]  readers_reg = READERS_RESET;

  int send_idle = 0;
  int recv_idle = 0;
  int issued    = 0;
  int retired   = 0;
  int errors    = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // One command applied to a slot table under the current register settings.
  function automatic result_t slot_table_step(inout table_t t, input cmd_t c);
    result_t                r;
    int                     n_slots;
    int                     n_readers;
    logic [MAX_READERS-1:0] need;
    logic                   hit;
    r         = '0;
    hit       = 1'b0;
    n_slots   = (slots_reg > MAX_SLOTS) ? MAX_SLOTS : int'(slots_reg);
    n_readers = (readers_reg > MAX_READERS) ? MAX_READERS : int'(readers_reg);
    need      = MAX_READERS'((1 << n_readers) - 1);
    case (c.func)
      FUNC_WRITE: begin
        r.status = ST_NO_SPACE;
        for (int i = 0; i < n_slots; i++) begin
          if (!hit && t.val[i] == '0) begin
            // a zero value still claims the slot, which then stays empty
            hit          = 1'b1;
            t.val[i]     = c.value;
            t.marks[i]   = '0;
            r.status     = ST_WRITTEN;
            r.slot_written = SLOT_W'(i);
          end
        end
      end
      FUNC_READ: begin
        if (t.val[c.slot] == '0) begin
          r.status = ST_EMPTY;
        end else if (t.marks[c.slot][c.reader]) begin
          r.status = ST_ALREADY;
        end else begin
          t.marks[c.slot][c.reader] = 1'b1;
          // inactive readers mark but never count toward freeing
          if ((t.marks[c.slot] & need) == need) begin
            t.val[c.slot]   = '0;
            t.marks[c.slot] = '0;
          end
          r.status = ST_READ_OK;
        end
      end
      FUNC_CHECK: begin
        r.all_read = 1'b1;
        for (int i = 0; i < n_slots; i++) begin
          if (t.val[i] != '0 && !t.marks[i][c.reader]) r.all_read = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Random word, mostly reads aimed at occupied slots by readers that still
  // owe a mark, so slots actually cycle through fill and free.
  function automatic cmd_t plan_cmd();
    cmd_t    c;
    int      pick;
    int      n_readers;
    int      busy[$];
    int      unread[$];
    result_t ignored;
    c.value  = VALUE_W'($urandom);
    c.reader = READER_W'($urandom);
    c.slot   = SLOT_W'($urandom);
    pick     = $urandom_range(99);
    if (pick < 30) begin
      c.func = FUNC_WRITE;
      if (pick < 2) begin
        c.value = '0;
      end else if (pick < 4) begin
        c.value = '1;
      end else if (c.value == '0) begin
        c.value = VALUE_W'(1);
      end
    end else if (pick < 80) begin
      c.func = FUNC_READ;
      if (pick < 72) begin
        for (int s = 0; s < MAX_SLOTS; s++) begin
          if (plan_table.val[s] != '0) busy.push_back(s);
        end
        if (busy.size() != 0) begin
          c.slot    = SLOT_W'(busy[$urandom_range(busy.size() - 1)]);
          n_readers = (readers_reg > MAX_READERS) ? MAX_READERS : int'(readers_reg);
          if (n_readers == 0) n_readers = MAX_READERS;
          for (int r = 0; r < n_readers; r++) begin
            if (!plan_table.marks[c.slot][r]) unread.push_back(r);
          end
          if (unread.size() != 0) c.reader = READER_W'(unread[$urandom_range(unread.size() - 1)]);
        end
      end
    end else if (pick < 95) begin
      c.func = FUNC_CHECK;
    end else begin
      c.func = FUNC_NOP;
    end
    ignored = slot_table_step(plan_table, c);
    return c;
  endfunction

  task automatic queue_cmd(input cmd_t c);
    cmd_backlog.push_back(c);
    issued++;
  endtask

  task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                          input int r, input int s);
    queue_cmd(cmd_t'{f, v, READER_W'(r), SLOT_W'(s)});
  endtask

  // register write; only issued while no word is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLOTS_IN_USE) begin
      slots_reg = NSLOT_W'(data);
    end else begin
      readers_reg = NRDR_W'(data);
    end
  endtask

  // every word queued so far has come back as a result word
  task automatic drain();
    while (retired != issued) @(posedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next word unless idling.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = slot_table_step(live_table, bus_cmd);
        pending_results.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
          bus_cmd = cmd_backlog.pop_front();
          in_valid   <= 1'b1;
          func       <= bus_cmd.func;
          value      <= bus_cmd.value;
          reader     <= bus_cmd.reader;
          slot_index <= bus_cmd.slot;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted result word.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with no command outstanding");
          errors++;
        end else begin
          observed = pending_results.pop_front();
          retired++;
          if (status !== observed.status) begin
            $error("status: expected %0d, got %0d", observed.status, status);
            errors++;
          end
          if (slot_written !== observed.slot_written) begin
            $error("slot_written: expected %0d, got %0d", observed.slot_written, slot_written);
            errors++;
          end
          if (all_read !== observed.all_read) begin
            $error("all_read: expected %0d, got %0d", observed.all_read, all_read);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: two slots, two active readers
    write_reg(CFG_SLOTS_IN_USE, 5'd2);
    write_reg(CFG_READERS_IN_USE, 5'd2);
    send_idle = 24;
    recv_idle = 71;
    push_cmd(FUNC_CHECK, '0, 0, 0);                // empty table counts as done
    push_cmd(FUNC_READ,  '0, 0, 0);                // slot empty
    push_cmd(FUNC_WRITE, '1, 0, 0);                // max value into slot 0
    push_cmd(FUNC_WRITE, '0, 0, 0);                // zero value: slot 1 stays empty
    push_cmd(FUNC_WRITE, VALUE_W'(1), 0, 0);       // so slot 1 is taken again
    push_cmd(FUNC_WRITE, VALUE_W'(5), 0, 0);       // no space
    push_cmd(FUNC_READ,  '0, 0, 15);               // beyond window, empty
    push_cmd(FUNC_READ,  '0, 0, 0);
    push_cmd(FUNC_READ,  '0, 0, 0);                // already read
    push_cmd(FUNC_CHECK, '0, 0, 0);                // slot 1 still unread
    push_cmd(FUNC_READ,  '0, 7, 0);                // inactive reader marks, no free
    push_cmd(FUNC_CHECK, '0, 7, 0);
    push_cmd(FUNC_READ,  '0, 1, 0);                // last active reader frees slot 0
    push_cmd(FUNC_READ,  '0, 1, 0);                // now empty
    push_cmd(FUNC_NOP,   '1, 7, 15);               // unknown func, all-zero answer
    push_cmd(FUNC_READ,  '0, 1, 1);
    push_cmd(FUNC_CHECK, '0, 1, 0);
    push_cmd(FUNC_READ,  '0, 0, 1);                // frees slot 1
    push_cmd(FUNC_CHECK, '0, 0, 0);
    push_cmd(FUNC_WRITE, VALUE_W'(31'h2AAAAAAA), 0, 0);
    push_cmd(FUNC_WRITE, VALUE_W'(31'h55555555), 0, 0);
    push_cmd(FUNC_READ,  '0, 6, 1);
    drain();

    // random phases: sender-light, then receiver-light, then no idling
    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(CFG_SLOTS_IN_USE, PHASE_SLOTS[p]);
      write_reg(CFG_READERS_IN_USE, PHASE_READERS[p]);
      send_idle = (p < 3) ? 24 : (p < 6) ? 71 : 0;
      recv_idle = (p < 3) ? 71 : (p < 6) ? 24 : 0;
      plan_table = live_table;
      repeat (PHASE_WORDS) queue_cmd(plan_cmd());
      drain();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/bsb_pkg.sv
rtl/bsb_ctrl.sv
rtl/bsb_datapath.sv
rtl/broadcast_slot_buffer_unit.sv
sim/broadcast_slot_buffer_unit_tb.sv
